[src/rsl_pkg.sv]
// Shared types and constants for the RIFF sub-chunk locator.
`timescale 1ns / 1ps

package rsl_pkg;

	typedef enum logic [1:0] {
		PH_MAGIC,
		PH_TOP,
		PH_LIST,
		PH_IDLE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NOT_SF2,
		ST_CORRUPT,
		ST_NO_SMPL,
		ST_NO_SHDR
	} status_t;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// four-character codes, first character in the top byte
	localparam logic [31:0] ID_RIFF = 32'h52494646;
	localparam logic [31:0] ID_SFBK = 32'h7366626B;
	localparam logic [31:0] ID_LIST = 32'h4C495354;

	// index order is the chunk_id code: smpl phdr pbag pgen inst ibag igen shdr
	localparam logic [31:0] WANTED_IDS [8] = '{
		32'h736D706C, 32'h70686472, 32'h70626167, 32'h7067656E,
		32'h696E7374, 32'h69626167, 32'h6967656E, 32'h73686472
	};

	localparam int SHDR_BIT = 7;
	localparam int SMPL_BIT = 0;
	localparam logic [31:0] SHDR_MIN = 32'd46;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// everything one file byte produces: an optional record, an optional status
	typedef struct packed {
		logic        rec_v;
		logic [2:0]  rec_id;
		logic [31:0] rec_off;
		logic [31:0] rec_len;
		logic        fin_v;
		status_t     fin_status;
	} entry_t;

endpackage

[src/riff_subchunk_locator_unit.sv]
// Top level of the RIFF sub-chunk locator: parser, result queue, output side.
`timescale 1ns / 1ps

// Streams a SoundFont file in one byte per transaction, checks the RIFF/sfbk
// magic, walks the top-level chunks and the sub-chunks of every LIST, and
// reports the first sub-chunk of each of the eight wanted ids (offset of its
// data, declared length) and then, on the byte flagged end_of_file, one final
// status, after which the block is ready for a new file. A byte is taken every
// clock while data_ready is high; results exit one per cycle while result_ready
// is high. The parser writes a four-entry queue holding everything one byte
// produces, and data_ready drops only while that queue is full, which takes
// result_ready held low. A byte that both completes a wanted header and ends the
// file yields two transactions back to back. Positions are tracked in OFFSET_BITS
// bits; a byte at offset 2^OFFSET_BITS-1 or later marks the file corrupt.

module riff_subchunk_locator_unit #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        result_kind,
	output logic [2:0]  chunk_id,
	output logic [31:0] data_offset,
	output logic [31:0] chunk_length,
	output logic [2:0]  final_status,
	output logic        last_of_run
);

	logic            push;
	rsl_pkg::entry_t push_entry;
	rsl_pkg::entry_t head;
	logic            q_full;
	logic            q_empty;
	logic            pop;

	rsl_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_byte  (data_byte),
		.end_of_file(end_of_file),
		.q_full     (q_full),
		.data_ready (data_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	rsl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rsl_drain u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_kind (result_kind),
		.chunk_id    (chunk_id),
		.data_offset (data_offset),
		.chunk_length(chunk_length),
		.final_status(final_status),
		.last_of_run (last_of_run)
	);

endmodule

[src/rsl_front.sv]
// Byte parser: magic check, top-level chunk walk and LIST sub-chunk walk.
`timescale 1ns / 1ps

module rsl_front #(
	parameter int OFFSET_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            data_valid,
	input  logic [7:0]      data_byte,
	input  logic            end_of_file,
	input  logic            q_full,
	output logic            data_ready,
	output logic            push,
	output rsl_pkg::entry_t push_entry
);

	localparam int PW = OFFSET_BITS;
	localparam int EW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

	logic [PW-1:0]     pos_q, pos_d;
	rsl_pkg::phase_t   phase_q, phase_d, ph;
	logic [55:0]       shift_q;
	logic              magic_q, magic_d;
	logic              corrupt_q, corrupt_d;
	logic [7:0]        found_q, found_d;
	logic [31:0]       shdr_len_q, shdr_len_d;
	logic [EW-1:0]     outer_end_q, outer_end_d;
	logic [EW-1:0]     list_end_q, list_end_d;
	logic [EW-1:0]     sub_end_q, sub_end_d;
	logic [EW-1:0]     top_tgt_q, sub_hdr_end_q, sub_tgt_q, sub_room_q;
	logic              sub_fits_q;
	logic [1:0]        settle_q;
	logic              ends_wr;

	logic              take;
	logic              at_limit;
	logic [EW-1:0]     pos_x, at, sum;
	logic [63:0]       hdr;
	logic [31:0]       hid, len;
	logic [EW-1:0]     len_x;
	logic [7:0]        hit;
	logic [2:0]        hit_id;
	logic              rec_v;
	logic              over;
	rsl_pkg::status_t  status;

	assign data_ready = !q_full;
	assign take       = data_valid && data_ready;

	assign pos_x    = EW'(pos_q);
	assign at       = pos_x + EW'(1);
	assign hdr      = {shift_q, data_byte};
	assign hid      = hdr[63:32];
	assign len      = {hdr[7:0], hdr[15:8], hdr[23:16], hdr[31:24]};
	assign len_x    = EW'(len);
	assign sum      = pos_x + len_x + EW'(1);
	assign at_limit = &pos_q;

	always_comb begin
		hit    = '0;
		hit_id = '0;
		for (int k = 0; k < 8; k++) begin
			if (hid == rsl_pkg::WANTED_IDS[k] && !found_q[k]) begin
				hit[k] = 1'b1;
				hit_id = hit_id | 3'(k);
			end
		end
	end

	always_comb begin
		pos_d       = at_limit ? pos_q : pos_q + PW'(1);
		magic_d     = magic_q;
		corrupt_d   = corrupt_q;
		found_d     = found_q;
		shdr_len_d  = shdr_len_q;
		outer_end_d = outer_end_q;
		list_end_d  = list_end_q;
		sub_end_d   = sub_end_q;
		ends_wr     = 1'b0;
		rec_v       = 1'b0;
		over        = outer_end_q > at;
		ph          = phase_q;

		if (at_limit) begin
			corrupt_d = 1'b1;
			if (ph == rsl_pkg::PH_TOP || ph == rsl_pkg::PH_LIST)
				ph = rsl_pkg::PH_IDLE;
		end

		case (ph)
			rsl_pkg::PH_MAGIC: begin
				if (pos_q == PW'(3))
					magic_d = (hdr[31:0] == rsl_pkg::ID_RIFF);
				if (pos_q == PW'(11)) begin
					if (magic_q && hdr[31:0] == rsl_pkg::ID_SFBK) begin
						ph          = rsl_pkg::PH_TOP;
						outer_end_d = EW'(12);
						ends_wr     = 1'b1;
					end else begin
						magic_d = 1'b0;
						ph      = rsl_pkg::PH_IDLE;
					end
				end
			end
			rsl_pkg::PH_IDLE: begin
			end
			default: begin
				if (ph == rsl_pkg::PH_LIST && pos_x >= list_end_q)
					ph = rsl_pkg::PH_TOP;
				if (ph == rsl_pkg::PH_LIST) begin
					if (settle_q == 2'd0 && sub_fits_q && pos_x == sub_tgt_q) begin
						if (len_x > sub_room_q) begin
							corrupt_d = 1'b1;
							ph        = rsl_pkg::PH_IDLE;
						end else begin
							rec_v     = |hit;
							found_d   = found_q | hit;
							if (hit[rsl_pkg::SHDR_BIT])
								shdr_len_d = len;
							sub_end_d = sum;
							ends_wr   = 1'b1;
						end
					end
				end else if (ph == rsl_pkg::PH_TOP) begin
					if (settle_q == 2'd0 && pos_x == top_tgt_q) begin
						outer_end_d = sum;
						over        = (len != 32'd0);
						ends_wr     = 1'b1;
						if (hid == rsl_pkg::ID_LIST && len >= 32'd4) begin
							ph         = rsl_pkg::PH_LIST;
							list_end_d = sum;
							sub_end_d  = at + EW'(4);
						end
					end
				end
			end
		endcase
		phase_d = ph;

		if (ph == rsl_pkg::PH_MAGIC || !magic_d)
			status = rsl_pkg::ST_NOT_SF2;
		else if (corrupt_d || over)
			status = rsl_pkg::ST_CORRUPT;
		else if (!found_d[rsl_pkg::SMPL_BIT])
			status = rsl_pkg::ST_NO_SMPL;
		else if (!found_d[rsl_pkg::SHDR_BIT] || shdr_len_d < rsl_pkg::SHDR_MIN)
			status = rsl_pkg::ST_NO_SHDR;
		else
			status = rsl_pkg::ST_OK;

		// last byte: back to the power-on state for the next file
		if (end_of_file) begin
			pos_d       = '0;
			phase_d     = rsl_pkg::PH_MAGIC;
			magic_d     = 1'b0;
			corrupt_d   = 1'b0;
			found_d     = '0;
			shdr_len_d  = '0;
			outer_end_d = '0;
			list_end_d  = '0;
			sub_end_d   = '0;
			ends_wr     = 1'b1;
		end
	end

	assign push = take && (rec_v || end_of_file);

	always_comb begin
		push_entry.rec_v      = rec_v;
		push_entry.rec_id     = hit_id;
		push_entry.rec_off    = at[31:0];
		push_entry.rec_len    = len;
		push_entry.fin_v      = end_of_file;
		push_entry.fin_status = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rsl_pkg::PH_MAGIC;
		end else if (take) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			shift_q     <= '0;
			magic_q     <= 1'b0;
			corrupt_q   <= 1'b0;
			found_q     <= '0;
			shdr_len_q  <= '0;
			outer_end_q <= '0;
			list_end_q  <= '0;
			sub_end_q   <= '0;
		end else if (take) begin
			pos_q       <= pos_d;
			shift_q     <= end_of_file ? 56'd0 : hdr[55:0];
			magic_q     <= magic_d;
			corrupt_q   <= corrupt_d;
			found_q     <= found_d;
			shdr_len_q  <= shdr_len_d;
			outer_end_q <= outer_end_d;
			list_end_q  <= list_end_d;
			sub_end_q   <= sub_end_d;
		end
	end

	// header targets are registered from the chunk ends; settle_q masks the
	// compares meanwhile (the next header is at least eight bytes away)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_tgt_q     <= '0;
			sub_hdr_end_q <= '0;
			sub_tgt_q     <= '0;
			sub_fits_q    <= 1'b0;
			sub_room_q    <= '0;
			settle_q      <= 2'd0;
		end else begin
			top_tgt_q     <= outer_end_q + EW'(7) + EW'(outer_end_q[0]);
			sub_hdr_end_q <= sub_end_q + EW'(8) + EW'(sub_end_q[0]);
			sub_tgt_q     <= sub_hdr_end_q - EW'(1);
			sub_fits_q    <= (sub_hdr_end_q <= list_end_q);
			sub_room_q    <= list_end_q - sub_hdr_end_q;
			if (take && ends_wr)
				settle_q <= 2'd2;
			else if (settle_q != 2'd0)
				settle_q <= settle_q - 2'd1;
		end
	end

`ifndef ASSERT_OFF
	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_file |=> pos_q == '0 && phase_q == rsl_pkg::PH_MAGIC)
		else $error("parser did not restart after last byte");
`endif

endmodule

[src/rsl_queue.sv]
// Short queue of per-byte result entries between parser and output side.
`timescale 1ns / 1ps

module rsl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rsl_pkg::entry_t push_entry,
	input  logic            pop,
	output rsl_pkg::entry_t head,
	output logic            full,
	output logic            empty
);

	localparam int PTR_W = rsl_pkg::QPTR_W;

	rsl_pkg::entry_t  entries_q [rsl_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W + 1)'(rsl_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (PTR_W + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PTR_W + 1)'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + (PTR_W + 1)'(1))
		else $error("queue count lost a write");
`endif

endmodule

[src/rsl_drain.sv]
// Output side: turns each queued entry into one or two result transactions.
`timescale 1ns / 1ps

module rsl_drain (
	input  logic            clk,
	input  logic            arst_n,
	input  rsl_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_ready,
	output logic            result_kind,
	output logic [2:0]      chunk_id,
	output logic [31:0]     data_offset,
	output logic [31:0]     chunk_length,
	output logic [2:0]      final_status,
	output logic            last_of_run
);

	logic rec_done_q;
	logic show_rec;
	logic fire;

	assign show_rec     = head.rec_v && !rec_done_q;
	assign result_valid = !empty;
	assign fire         = result_valid && result_ready;
	// an entry with both parts leaves only after its status goes out
	assign pop          = fire && !(show_rec && head.fin_v);

	always_comb begin
		if (show_rec) begin
			result_kind  = rsl_pkg::KIND_RECORD;
			chunk_id     = head.rec_id;
			data_offset  = head.rec_off;
			chunk_length = head.rec_len;
			final_status = rsl_pkg::ST_OK;
			last_of_run  = !head.fin_v;
		end else begin
			result_kind  = rsl_pkg::KIND_STATUS;
			chunk_id     = '0;
			data_offset  = '0;
			chunk_length = '0;
			final_status = head.fin_status;
			last_of_run  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_done_q <= 1'b0;
		end else if (fire) begin
			rec_done_q <= !pop;
		end
	end

`ifndef ASSERT_OFF
	a_split_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rec_done_q |-> !empty && head.rec_v && head.fin_v)
		else $error("half-sent entry lost its status part");
`endif

endmodule

[tb/sv/tb_top.sv]
// Testbench for the RIFF sub-chunk locator: streams SoundFont byte files and checks each result.
`timescale 1ns / 1ps

module tb_top;

	localparam int OFFSET_BITS = 32;
	localparam bit [63:0] POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_BYTES = 560;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_REPORTS = 40;
	localparam int LONG_STALL = 80;

	localparam logic [31:0] ID_INFO = 32'h494E464F;
	localparam logic [31:0] ID_SDTA = 32'h73647461;
	localparam logic [31:0] ID_PDTA = 32'h70647461;
	localparam logic [31:0] ID_JUNK = 32'h4A554E4B;

	typedef struct packed {
		logic        kind;
		logic [2:0]  id;
		logic [31:0] off;
		logic [31:0] len;
		logic [2:0]  status;
		logic        last_flag;
	} locator_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        end_of_file = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        result_kind;
	logic [2:0]  chunk_id;
	logic [31:0] data_offset;
	logic [31:0] chunk_length;
	logic [2:0]  final_status;
	logic        last_of_run;

	riff_subchunk_locator_unit #(.OFFSET_BITS(OFFSET_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_kind(result_kind),
		.chunk_id(chunk_id),
		.data_offset(data_offset),
		.chunk_length(chunk_length),
		.final_status(final_status),
		.last_of_run(last_of_run)
	);

	// parser state mirrored by the predictor
	bit [63:0]        cur_pos;
	rsl_pkg::phase_t  phase;
	bit [63:0]        shift_win;
	bit [63:0]        top_end;
	bit [63:0]        lst_end;
	bit [63:0]        sub_end;
	bit [7:0]         ids_seen;
	bit [31:0]        shdr_bytes;
	bit               riff_ok;
	bit               broken;

	locator_result_t due_results[$];
	bit [7:0]        file_bytes[$];

	int cycles = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int stall_left = 0;
	int long_stalls_asked = 0;
	int long_stalls_taken = 0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(7, 30);
	endfunction

	function automatic void clear_parser();
		cur_pos = 64'd0;
		phase = rsl_pkg::PH_MAGIC;
		shift_win = 64'd0;
		top_end = 64'd0;
		lst_end = 64'd0;
		sub_end = 64'd0;
		ids_seen = 8'd0;
		shdr_bytes = 32'd0;
		riff_ok = 1'b0;
		broken = 1'b0;
	endfunction

	// length field of the header window, stored little-endian
	function automatic bit [63:0] le_length();
		return {32'd0, shift_win[7:0], shift_win[15:8], shift_win[23:16], shift_win[31:24]};
	endfunction

	// advance the mirrored parser by one accepted byte and queue what it produces
	function automatic void parse_byte(input logic [7:0] b, input logic eof);
		bit [63:0] pos, hs, len, total;
		bit [31:0] hid;
		locator_result_t outs [2];
		int n;
		rsl_pkg::status_t st;
		pos = cur_pos;
		n = 0;
		if (pos >= POS_MAX) begin
			broken = 1'b1;
			if (phase == rsl_pkg::PH_TOP || phase == rsl_pkg::PH_LIST)
				phase = rsl_pkg::PH_IDLE;
		end
		if (phase == rsl_pkg::PH_MAGIC) begin
			shift_win = {shift_win[55:0], b};
			if (pos == 64'd3)
				riff_ok = (shift_win[31:0] == rsl_pkg::ID_RIFF);
			if (pos >= 64'd11) begin
				if (riff_ok && shift_win[31:0] == rsl_pkg::ID_SFBK) begin
					phase = rsl_pkg::PH_TOP;
					top_end = 64'd12;
				end else begin
					riff_ok = 1'b0;
					phase = rsl_pkg::PH_IDLE;
				end
			end
		end else begin
			if (phase == rsl_pkg::PH_LIST && pos >= lst_end)
				phase = rsl_pkg::PH_TOP;
			if (phase == rsl_pkg::PH_LIST) begin
				hs = sub_end + 64'(sub_end[0]);
				if (pos >= hs && hs + 64'd8 <= lst_end) begin
					shift_win = {shift_win[55:0], b};
					if (pos - hs == 64'd7) begin
						len = le_length();
						hid = shift_win[63:32];
						if (hs + 64'd8 + len > lst_end) begin
							broken = 1'b1;
							phase = rsl_pkg::PH_IDLE;
						end else begin
							for (int k = 0; k < 8; k++) begin
								if (hid == rsl_pkg::WANTED_IDS[k] && !ids_seen[k]) begin
									ids_seen[k] = 1'b1;
									if (k == rsl_pkg::SHDR_BIT)
										shdr_bytes = len[31:0];
									outs[n] = '{rsl_pkg::KIND_RECORD, 3'(k),
										pos[31:0] + 32'd1, len[31:0],
										rsl_pkg::ST_OK, 1'b0};
									n++;
								end
							end
							sub_end = hs + 64'd8 + len;
						end
					end
				end
			end else if (phase == rsl_pkg::PH_TOP) begin
				hs = top_end + 64'(top_end[0]);
				if (pos >= hs) begin
					shift_win = {shift_win[55:0], b};
					if (pos - hs == 64'd7) begin
						len = le_length();
						top_end = pos + 64'd1 + len;
						if (shift_win[63:32] == rsl_pkg::ID_LIST && len >= 64'd4) begin
							phase = rsl_pkg::PH_LIST;
							lst_end = pos + 64'd1 + len;
							sub_end = pos + 64'd5;
						end
					end
				end
			end
		end
		if (eof) begin
			total = pos + 64'd1;
			if (phase == rsl_pkg::PH_MAGIC || !riff_ok)
				st = rsl_pkg::ST_NOT_SF2;
			else if (broken || top_end > total)
				st = rsl_pkg::ST_CORRUPT;
			else if (!ids_seen[rsl_pkg::SMPL_BIT])
				st = rsl_pkg::ST_NO_SMPL;
			else if (!ids_seen[rsl_pkg::SHDR_BIT] || shdr_bytes < rsl_pkg::SHDR_MIN)
				st = rsl_pkg::ST_NO_SHDR;
			else
				st = rsl_pkg::ST_OK;
			outs[n] = '{rsl_pkg::KIND_STATUS, 3'd0, 32'd0, 32'd0, st, 1'b0};
			n++;
			clear_parser();
		end else begin
			cur_pos = (pos >= POS_MAX) ? POS_MAX : pos + 64'd1;
		end
		for (int i = 0; i < n; i++) begin
			outs[i].last_flag = (i == n - 1);
			due_results.insert(due_results.size(), outs[i]);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("tb_top: mismatch in %s at cycle %0d: got 0x%0h, expected 0x%0h",
				what, cycles, got, want);
	endtask

	// ---------------- file building ----------------

	function automatic void add_byte(input logic [7:0] b);
		file_bytes.insert(file_bytes.size(), b);
	endfunction

	function automatic void add_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			add_byte(w[8*i +: 8]);
	endfunction

	function automatic void add_le32(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			add_byte(v[8*i +: 8]);
	endfunction

	function automatic void set_le32(input int at, input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			file_bytes[at + i] = v[8*i +: 8];
	endfunction

	function automatic void add_fill(input int n);
		repeat (n) add_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void begin_sf2();
		add_word(rsl_pkg::ID_RIFF);
		add_fill(4);
		add_word(rsl_pkg::ID_SFBK);
	endfunction

	// sub-chunk with random data and the pad byte when the length is odd
	function automatic void add_sub(input logic [31:0] sid, input int len);
		add_word(sid);
		add_le32(len);
		add_fill(len + (len % 2));
	endfunction

	// returns the index of the length field, patched later by end_list
	function automatic int start_list(input logic [31:0] list_kind);
		int at;
		add_word(rsl_pkg::ID_LIST);
		at = file_bytes.size();
		add_le32(32'd0);
		add_word(list_kind);
		return at;
	endfunction

	function automatic void end_list(input int at);
		set_le32(at, file_bytes.size() - at - 4);
	endfunction

	function automatic void add_random_sub();
		bit [31:0] sid;
		int r;
		sid = ($urandom_range(0, 3) != 0) ? rsl_pkg::WANTED_IDS[$urandom_range(0, 7)]
			: $urandom();
		r = $urandom_range(0, 19);
		if (r == 0) begin
			add_word(sid);
			add_le32($urandom());
			add_fill($urandom_range(0, 8));
		end else if (r < 3) begin
			add_sub(sid, $urandom_range(10, 60));
		end else begin
			add_sub(sid, $urandom_range(0, 9));
		end
	endfunction

	function automatic void add_random_list();
		int at, nsub, body, r;
		bit rich;
		rich = ($urandom_range(0, 9) < 4);
		at = start_list($urandom_range(0, 1) ? ID_PDTA : $urandom());
		nsub = $urandom_range(0, 5);
		if (rich)
			add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], $urandom_range(0, 6));
		for (int i = 0; i < nsub; i++)
			add_random_sub();
		if (rich)
			add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], $urandom_range(44, 52));
		body = file_bytes.size() - at - 4;
		r = $urandom_range(0, 19);
		if (r == 0)
			set_le32(at, $urandom_range(0, 3));
		else if (r == 1)
			set_le32(at, body + $urandom_range(1, 40));
		else if (r == 2)
			set_le32(at, $urandom());
		else if (r == 3 && body > 4)
			set_le32(at, $urandom_range(4, body - 1));
		else
			set_le32(at, body);
	endfunction

	function automatic void add_random_other();
		bit [31:0] len;
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			add_word(rsl_pkg::ID_LIST);
			len = $urandom_range(0, 3);
		end else begin
			add_word($urandom());
			len = $urandom_range(0, 12);
		end
		if (r == 1) begin
			add_le32($urandom());
			add_fill($urandom_range(0, 8));
		end else begin
			add_le32(len);
			add_fill(int'(len) + int'(len[0]));
		end
	endfunction

	function automatic void build_random_file();
		int r, nchunk, cut, idx;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			add_fill($urandom_range(1, 24));
			return;
		end
		begin_sf2();
		if (r < 13) begin
			idx = $urandom_range(0, 11);
			file_bytes[idx] = file_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
		end
		nchunk = $urandom_range(0, 3);
		for (int c = 0; c < nchunk; c++) begin
			if ($urandom_range(0, 3) != 0)
				add_random_list();
			else
				add_random_other();
		end
		if ($urandom_range(0, 9) == 0)
			add_fill($urandom_range(1, 7));
		if ($urandom_range(0, 9) == 0 && file_bytes.size() > 1) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			repeat (cut) void'(file_bytes.pop_back());
		end
	endfunction

	// ---------------- driving ----------------

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = 0;
		if (send_idle_on && $urandom_range(0, 3) == 0)
			gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			data_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid = 1'b1;
		data_byte = b;
		end_of_file = last;
		do @(posedge clk); while (!data_ready);
		parse_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_file();
		int n;
		n = file_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(file_bytes[i], i == n - 1);
		file_bytes.delete();
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		data_valid = 1'b0;
		end_of_file = 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (long_stalls_taken != long_stalls_asked) begin
			long_stalls_taken = long_stalls_asked;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			result_ready = 1'b0;
			stall_left--;
		end else begin
			result_ready = 1'b1;
			if (recv_idle_on && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		locator_result_t want;
		if (result_valid === 1'b1 && result_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result", {31'd0, result_kind}, 32'd0);
			end else begin
				want = due_results.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
				if (chunk_id !== want.id)
					report_mismatch("chunk_id", 32'(chunk_id), 32'(want.id));
				if (data_offset !== want.off)
					report_mismatch("data_offset", data_offset, want.off);
				if (chunk_length !== want.len)
					report_mismatch("chunk_length", chunk_length, want.len);
				if (final_status !== want.status)
					report_mismatch("final_status", 32'(final_status), 32'(want.status));
				if (last_of_run !== want.last_flag)
					report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last_flag));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ---------------- tests ----------------

	task automatic test_short_and_bad_magic();
		add_byte(8'hFF);
		send_file();
		// eleven bytes: magic never completes
		begin_sf2();
		void'(file_bytes.pop_back());
		send_file();
		// wrong form type, then a well-formed sub-chunk that must be ignored
		begin_sf2();
		file_bytes[11] = 8'h00;
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 2);
		send_file();
		// wrong RIFF tag with a correct form type
		begin_sf2();
		file_bytes[3] = 8'h58;
		add_fill(10);
		send_file();
		// magic alone, file ends on byte twelve
		begin_sf2();
		send_file();
	endtask

	task automatic test_complete_file();
		int at;
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		begin_sf2();
		add_word(ID_JUNK);
		add_le32(32'd3);
		add_fill(4);
		at = start_list(ID_INFO);
		add_sub(32'h69666976, 4);
		end_list(at);
		at = start_list(ID_SDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 6);
		end_list(at);
		at = start_list(ID_PDTA);
		for (int k = 1; k < 7; k++)
			add_sub(rsl_pkg::WANTED_IDS[k], k);
		// a second smpl is not reported
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 2);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 46);
		end_list(at);
		send_file();
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	task automatic test_missing_chunks();
		int at;
		begin_sf2();
		at = start_list(ID_PDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 46);
		end_list(at);
		send_file();
		begin_sf2();
		at = start_list(ID_PDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 0);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 45);
		end_list(at);
		send_file();
		begin_sf2();
		at = start_list(ID_SDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 3);
		end_list(at);
		send_file();
		// only the first shdr counts, even when a later one is long enough
		begin_sf2();
		at = start_list(ID_PDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 1);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 10);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 46);
		end_list(at);
		send_file();
	endtask

	task automatic test_overruns();
		int at;
		// sub-chunk runs past its list: corrupt at once, earlier record stands
		begin_sf2();
		at = start_list(ID_PDTA);
		add_sub(rsl_pkg::WANTED_IDS[1], 2);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 10);
		set_le32(at, 4 + 10 + 8 + 4);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 46);
		send_file();
		// all-ones sub-chunk length
		begin_sf2();
		at = start_list(ID_PDTA);
		add_word(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT]);
		add_le32(32'hFFFF_FFFF);
		add_fill(6);
		end_list(at);
		send_file();
		// list longer than the file: records come out, corrupt at end of file
		begin_sf2();
		at = start_list(ID_PDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 4);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 46);
		set_le32(at, file_bytes.size() - at - 4 + 30);
		send_file();
		// plain top-level chunk with an all-ones length
		begin_sf2();
		add_word(ID_JUNK);
		add_le32(32'hFFFF_FFFF);
		add_fill(9);
		send_file();
	endtask

	task automatic test_partial_and_small_lists();
		int at;
		// trailing partial header at top level is not an error
		begin_sf2();
		at = start_list(ID_PDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 2);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 46);
		end_list(at);
		add_fill(7);
		send_file();
		// list with an odd length holding only a partial sub header, then pad
		begin_sf2();
		at = start_list(ID_INFO);
		add_fill(5);
		end_list(at);
		add_fill(1);
		// lists shorter than the list type, and an empty one
		add_word(rsl_pkg::ID_LIST);
		add_le32(32'd2);
		add_fill(2);
		add_word(rsl_pkg::ID_LIST);
		add_le32(32'd3);
		add_fill(4);
		at = start_list(ID_SDTA);
		end_list(at);
		at = start_list(ID_PDTA);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT], 0);
		add_sub(rsl_pkg::WANTED_IDS[rsl_pkg::SHDR_BIT], 50);
		end_list(at);
		send_file();
	endtask

	task automatic test_record_on_last_byte();
		int at;
		// last byte of the file completes a wanted header: record and status together
		begin_sf2();
		at = start_list(ID_PDTA);
		add_word(rsl_pkg::WANTED_IDS[rsl_pkg::SMPL_BIT]);
		add_le32(32'd0);
		end_list(at);
		send_file();
	endtask

	task automatic test_backpressure();
		wait_all_results();
		// hold the result side off long enough to fill the result queue
		long_stalls_asked++;
		for (int i = 0; i < 12; i++) begin
			add_byte((i == 0) ? 8'h00 : (i == 11) ? 8'hFF : 8'($urandom()));
			send_file();
		end
		wait_all_results();
	endtask

	task automatic test_random_files();
		int start, files;
		start = bytes_sent;
		files = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			send_idle_on = ($urandom_range(0, 4) != 0);
			recv_idle_on = ($urandom_range(0, 4) != 0);
			build_random_file();
			send_file();
			files++;
			if (files % 6 == 0)
				wait_all_results();
		end
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	initial begin
		clear_parser();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_short_and_bad_magic();
		test_complete_file();
		test_missing_chunks();
		test_overruns();
		test_partial_and_small_lists();
		test_record_on_last_byte();
		test_backpressure();
		test_random_files();
		wait_all_results();
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
